// ===== design/llt_pkg.sv =====
// Shared types, token codes and keyword table for the logic language tokenizer.
// Used by llt_front, llt_fifo, llt_back and logic_language_tokenizer.
package llt_pkg;

  // Longest identifier accepted, in characters (5..255)
  localparam int MAX_ID_LEN = 255;
  // Identifier bytes kept for keyword matching
  localparam int PREFIX_LEN = 5;
  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  // Token kinds (keywords are 0..7, index into KW_TEXT)
  localparam logic [4:0] TK_LPAR   = 5'd8;
  localparam logic [4:0] TK_RPAR   = 5'd9;
  localparam logic [4:0] TK_LSPAR  = 5'd10;
  localparam logic [4:0] TK_RSPAR  = 5'd11;
  localparam logic [4:0] TK_PERIOD = 5'd12;
  localparam logic [4:0] TK_COMMA  = 5'd13;
  localparam logic [4:0] TK_QUERY  = 5'd14;
  localparam logic [4:0] TK_ASSIGN = 5'd15;
  localparam logic [4:0] TK_ATOM   = 5'd16;
  localparam logic [4:0] TK_VAR    = 5'd17;
  localparam logic [4:0] TK_INT    = 5'd18;
  localparam logic [4:0] TK_END    = 5'd19;
  localparam logic [4:0] TK_ERR    = 5'd20;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DASH = 2'd1;
  localparam logic [1:0] ERR_CHAR = 2'd2;
  localparam logic [1:0] ERR_LONG = 2'd3;

  // Character classes produced by the front end
  typedef enum logic [3:0] {
    CL_END, CL_BLANK, CL_NL, CL_HASH, CL_PUNCT, CL_QMARK, CL_COLON,
    CL_DASH, CL_DIGIT, CL_UPPER, CL_LOWER, CL_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [4:0]  punct;   // token kind for single-character punctuation
    logic [7:0]  ch;
  } char_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] ival;
    logic        ovf;
    logic [7:0]  len;
    logic [1:0]  err;
  } token_t;

  localparam token_t TOK_ZERO = '0;

  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

  typedef struct packed {
    logic halted;   // error seen, waiting for reset
    logic second;   // output holds first of two tokens from one byte
  } back_status_t;

  // Keyword text, byte 0 in the low byte, zero padded
  localparam prefix_t KW_TEXT [8] = '{
    {"t", "n", "i", "r", "p"},
    {8'h00, 8'h00, 8'h00, "l", "n"},
    {8'h00, 8'h00, 8'h00, "q", "e"},
    {8'h00, 8'h00, 8'h00, "f", "i"},
    {8'h00, 8'h00, 8'h00, "r", "o"},
    {8'h00, 8'h00, "t", "o", "n"},
    {8'h00, "l", "l", "a", "c"},
    {8'h00, "e", "c", "n", "o"}
  };
  localparam logic [7:0] KW_LEN [8] = '{8'd5, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd4, 8'd4};

  // Keyword index for a lower-case identifier, else atom
  function automatic logic [4:0] kw_lookup(input prefix_t pfx, input logic [7:0] cnt);
    logic [4:0] kind;
    kind = TK_ATOM;
    for (int k = 7; k >= 0; k--) begin
      if (cnt == KW_LEN[k] && pfx == KW_TEXT[k]) begin
        kind = 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ===== design/llt_front.sv =====
// Front end: classifies each source byte into a character class.
// Depends on llt_pkg.
module llt_front (
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  output llt_pkg::char_item_t item
);

  // Byte classification
  always_comb begin
    item.ch    = char_code;
    item.punct = llt_pkg::TK_LPAR;
    item.cls   = llt_pkg::CL_OTHER;
    if (end_of_input || char_code == 8'h00) begin
      item.cls = llt_pkg::CL_END;
    end else begin
      case (char_code) inside
        8'h20:          item.cls = llt_pkg::CL_BLANK;
        8'h0A:          item.cls = llt_pkg::CL_NL;
        8'h23:          item.cls = llt_pkg::CL_HASH;
        8'h28: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_LPAR;
        end
        8'h29: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_RPAR;
        end
        8'h5B: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_LSPAR;
        end
        8'h5D: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_RSPAR;
        end
        8'h2E: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_PERIOD;
        end
        8'h2C: begin
          item.cls = llt_pkg::CL_PUNCT; item.punct = llt_pkg::TK_COMMA;
        end
        8'h3F:          item.cls = llt_pkg::CL_QMARK;
        8'h3A:          item.cls = llt_pkg::CL_COLON;
        8'h2D:          item.cls = llt_pkg::CL_DASH;
        [8'h30:8'h39]:  item.cls = llt_pkg::CL_DIGIT;
        [8'h41:8'h5A]:  item.cls = llt_pkg::CL_UPPER;
        [8'h61:8'h7A]:  item.cls = llt_pkg::CL_LOWER;
        default:        item.cls = llt_pkg::CL_OTHER;
      endcase
    end
  end

endmodule

// ===== design/llt_fifo.sv =====
// Short queue of classified bytes between front and back.
// Depends on llt_pkg.
module llt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  llt_pkg::char_item_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output llt_pkg::char_item_t pop_data
);

  llt_pkg::char_item_t          slot_r [llt_pkg::QDEPTH];
  logic [llt_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [llt_pkg::QAW:0]        count_r;
  logic                         do_push, do_pop;

  assign push_ready = count_r != (llt_pkg::QAW+1)'(llt_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== design/llt_back.sv =====
// Back end: lexer state machine and result register.
// Depends on llt_pkg; takes classified bytes from llt_fifo.
module llt_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  llt_pkg::char_item_t    q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output llt_pkg::token_t        out_tok,
  output logic                   out_last,
  output llt_pkg::back_status_t  status
);

  typedef enum logic [6:0] {
    M_START   = 7'b0000001,
    M_COMMENT = 7'b0000010,
    M_QMARK   = 7'b0000100,
    M_COLON   = 7'b0001000,
    M_INT     = 7'b0010000,
    M_IDENT   = 7'b0100000,
    M_HALT    = 7'b1000000
  } lex_mode_t;

  lex_mode_t        mode_r, mode_nxt, sb_mode;
  logic [30:0]      acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  llt_pkg::prefix_t pfx_r, pfx_nxt;
  logic             upper_r, upper_nxt;
  logic             second_r;

  llt_pkg::token_t  out_tok_r, tok0, tok1, sb_tok;
  logic             out_valid_r, out_last_r;

  logic             sb_emit, sb_int, sb_id, apply_sb, pend;
  logic [1:0]       n_tok;
  logic [3:0]       digit;
  logic [34:0]      acc_x10;
  logic             is_alnum, slot_free, step, load;

  assign digit    = 4'(q_item.ch - 8'h30);
  assign is_alnum = q_item.cls == llt_pkg::CL_DIGIT || q_item.cls == llt_pkg::CL_UPPER ||
                    q_item.cls == llt_pkg::CL_LOWER;
  // acc*10 + digit as shift-and-add
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, digit};

  // What a byte does as the first byte of a new token
  always_comb begin
    sb_emit = 1'b0;
    sb_tok  = llt_pkg::TOK_ZERO;
    sb_mode = M_START;
    sb_int  = 1'b0;
    sb_id   = 1'b0;
    case (q_item.cls)
      llt_pkg::CL_END: begin
        sb_emit = 1'b1; sb_tok.kind = llt_pkg::TK_END;
      end
      llt_pkg::CL_BLANK, llt_pkg::CL_NL: sb_mode = M_START;
      llt_pkg::CL_HASH:  sb_mode = M_COMMENT;
      llt_pkg::CL_PUNCT: begin
        sb_emit = 1'b1; sb_tok.kind = q_item.punct;
      end
      llt_pkg::CL_QMARK: sb_mode = M_QMARK;
      llt_pkg::CL_COLON: sb_mode = M_COLON;
      llt_pkg::CL_DIGIT: begin
        sb_mode = M_INT; sb_int = 1'b1;
      end
      llt_pkg::CL_UPPER, llt_pkg::CL_LOWER: begin
        sb_mode = M_IDENT; sb_id = 1'b1;
      end
      default: begin
        sb_emit = 1'b1; sb_tok.kind = llt_pkg::TK_ERR; sb_tok.err = llt_pkg::ERR_CHAR;
        sb_mode = M_HALT;
      end
    endcase
  end

  // Lexer step for the byte at the head of the queue
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    pfx_nxt   = pfx_r;
    upper_nxt = upper_r;
    tok0      = llt_pkg::TOK_ZERO;
    tok1      = llt_pkg::TOK_ZERO;
    n_tok     = 2'd0;
    apply_sb  = 1'b0;
    pend      = 1'b0;
    case (mode_r)
      M_HALT: n_tok = 2'd0;
      M_COMMENT: begin
        if (q_item.cls == llt_pkg::CL_END) apply_sb = 1'b1;
        else if (q_item.cls == llt_pkg::CL_NL) mode_nxt = M_START;
      end
      M_QMARK, M_COLON: begin
        n_tok = 2'd1;
        if (q_item.cls == llt_pkg::CL_DASH) begin
          tok0.kind = (mode_r == M_QMARK) ? llt_pkg::TK_QUERY : llt_pkg::TK_ASSIGN;
          mode_nxt  = M_START;
        end else begin
          tok0.kind = llt_pkg::TK_ERR;
          tok0.err  = llt_pkg::ERR_DASH;
          mode_nxt  = M_HALT;
        end
      end
      M_INT: begin
        if (q_item.cls == llt_pkg::CL_DIGIT) begin
          if (acc_x10 > {4'd0, llt_pkg::INT_MAX31}) begin
            acc_nxt = llt_pkg::INT_MAX31;
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = acc_x10[30:0];
          end
        end else begin
          pend      = 1'b1;
          tok0.kind = llt_pkg::TK_INT;
          tok0.ival = acc_r;
          tok0.ovf  = ovf_r;
          apply_sb  = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alnum) begin
          if (cnt_r >= 8'(llt_pkg::MAX_ID_LEN)) begin
            n_tok     = 2'd1;
            tok0.kind = llt_pkg::TK_ERR;
            tok0.err  = llt_pkg::ERR_LONG;
            mode_nxt  = M_HALT;
          end else begin
            if (cnt_r < 8'(llt_pkg::PREFIX_LEN)) pfx_nxt[cnt_r[2:0]] = q_item.ch;
            cnt_nxt = cnt_r + 8'd1;
          end
        end else begin
          pend      = 1'b1;
          tok0.kind = upper_r ? llt_pkg::TK_VAR : llt_pkg::kw_lookup(pfx_r, cnt_r);
          tok0.len  = cnt_r;
          apply_sb  = 1'b1;
        end
      end
      default: apply_sb = 1'b1;
    endcase

    // New token started by this byte, and the one or two tokens it emits
    if (apply_sb) begin
      mode_nxt = sb_mode;
      if (sb_int) begin
        acc_nxt = {27'd0, digit};
        ovf_nxt = 1'b0;
      end
      if (sb_id) begin
        pfx_nxt    = '0;
        pfx_nxt[0] = q_item.ch;
        cnt_nxt    = 8'd1;
        upper_nxt  = q_item.cls == llt_pkg::CL_UPPER;
      end
      if (sb_emit && pend) begin
        n_tok = 2'd2;
        tok1  = sb_tok;
      end else if (sb_emit) begin
        n_tok = 2'd1;
        tok0  = sb_tok;
      end else if (pend) begin
        n_tok = 2'd1;
      end
    end
  end

  // Handshake: a two-token byte stays at the queue head until its second token is loaded
  assign slot_free = !out_valid_r || out_ready;
  assign step      = q_valid && slot_free;
  assign q_pop     = step && !(n_tok == 2'd2 && !second_r);
  assign load      = step && n_tok != 2'd0;

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
      pfx_r    <= '0;
      upper_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (step) second_r <= n_tok == 2'd2 && !second_r;
      if (q_pop) begin
        mode_r  <= mode_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        cnt_r   <= cnt_nxt;
        pfx_r   <= pfx_nxt;
        upper_r <= upper_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= second_r ? tok1 : tok0;
      out_last_r <= n_tok == 2'd1 || second_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tok       = out_tok_r;
  assign out_last      = out_last_r;
  assign status.halted = mode_r == M_HALT;
  assign status.second = second_r;

endmodule

// ===== design/logic_language_tokenizer.sv =====
// Top level of the logic language tokenizer: front classifier, queue, lexer back end.
// Depends on llt_pkg, llt_front, llt_fifo and llt_back.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_char_code, in_end_of_input
//   out     | output    | out_valid / out_ready | out_ token_kind .. last, six fields
//
// One byte is accepted per cycle while the four-entry queue has room.
// The lexer back end retires one byte per cycle while the queue holds a byte and the
// result register is free; a byte that ends a number or identifier and also forms a token of
// its own yields two tokens in turn. A byte waits in a queue slot, then its token is registered.
// Reset is synchronous and clears the queue, lexer state and result register.
// After an error token the block keeps accepting bytes but emits nothing until reset.
module logic_language_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [30:0] out_int_value,
  output logic        out_int_overflow,
  output logic [7:0]  out_ident_length,
  output logic [1:0]  out_error_kind,
  output logic        out_last
);

  llt_pkg::char_item_t   fr_item, q_item;
  logic                  q_valid, q_pop;
  llt_pkg::token_t       tok;
  llt_pkg::back_status_t st;

  llt_front u_front (
    .char_code    (in_char_code),
    .end_of_input (in_end_of_input),
    .item         (fr_item)
  );

  llt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (fr_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_item)
  );

  llt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (tok),
    .out_last  (out_last),
    .status    (st)
  );

  assign out_token_kind   = tok.kind;
  assign out_int_value    = tok.ival;
  assign out_int_overflow = tok.ovf;
  assign out_ident_length = tok.len;
  assign out_error_kind   = tok.err;

  // An error token leaves the lexer halted
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == llt_pkg::TK_ERR) |-> st.halted)
    else $error("error token without halt");

  // Halt holds until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st.halted |=> st.halted)
    else $error("left halt without reset");

  // While the second token is pending, the first sits in the output, not last
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    st.second |-> (out_valid && !out_last))
    else $error("token pair out of order");

  // Only integer tokens carry a value
  a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind != llt_pkg::TK_INT) |->
      (out_int_value == 31'd0 && !out_int_overflow))
    else $error("value on non-integer token");

endmodule

// ===== tb/sv/logic_language_tokenizer_test.sv =====
// Self-checking testbench for logic_language_tokenizer: a short directed byte table, then
// random source text, with every token checked against the in-bench lexer model or a typed row.
// Depends on llt_pkg and the logic_language_tokenizer RTL.
module logic_language_tokenizer_test;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 1700;
  localparam int IDLE_PCT     = 24;
  // Keyword kinds are positions in kw_spell; print is the first
  localparam logic [4:0] TK_PRINT = 5'd0;

  typedef enum logic [6:0] {
    MD_START   = 7'b0000001,
    MD_COMMENT = 7'b0000010,
    MD_QMARK   = 7'b0000100,
    MD_COLON   = 7'b0001000,
    MD_INT     = 7'b0010000,
    MD_IDENT   = 7'b0100000,
    MD_HALT    = 7'b1000000
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t                             mode;
    logic [30:0]                           acc;
    logic                                  ovf;
    logic [7:0]                            cnt;
    logic [llt_pkg::PREFIX_LEN-1:0][7:0]   pfx;
    logic                                  upper;
  } lex_state_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] ival;
    logic        ovf;
    logic [7:0]  len;
    logic [1:0]  err;
    logic        last;
  } lex_tok_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    logic        typed;
    logic [4:0]  kind;
    logic [30:0] ival;
    logic        ovf;
    logic [7:0]  len;
    logic [1:0]  err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_token_kind;
  logic [30:0] out_int_value;
  logic        out_int_overflow;
  logic [7:0]  out_ident_length;
  logic [1:0]  out_error_kind;
  logic        out_last;

  lex_state_t  lex;
  lex_tok_t    pending_toks [$];
  lex_tok_t    head;
  int          fails = 0;
  int          bytes_in = 0;
  int          stuck_cycles = 0;
  int          idle_pct = IDLE_PCT;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;

  string kw_spell [8] = '{"print", "nl", "eq", "if", "or", "not", "call", "once"};
  string seps = " \n()[].,";

  // Directed bytes; typed rows give the last token of that transaction by hand
  dir_row_t dir_rows [25] = '{
    '{8'hFF, 1'b1, 1'b1, llt_pkg::TK_END,    31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"(",   1'b0, 1'b1, llt_pkg::TK_LPAR,   31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{")",   1'b0, 1'b1, llt_pkg::TK_RPAR,   31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"[",   1'b0, 1'b1, llt_pkg::TK_LSPAR,  31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"]",   1'b0, 1'b1, llt_pkg::TK_RSPAR,  31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{".",   1'b0, 1'b1, llt_pkg::TK_PERIOD, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{",",   1'b0, 1'b1, llt_pkg::TK_COMMA,  31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"?",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"-",   1'b0, 1'b1, llt_pkg::TK_QUERY,  31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{":",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"-",   1'b0, 1'b1, llt_pkg::TK_ASSIGN, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"#",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"\n",  1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"p",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"r",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"i",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"n",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"t",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"(",   1'b0, 1'b1, llt_pkg::TK_LPAR,   31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"X",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"1",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{8'h00, 1'b0, 1'b1, llt_pkg::TK_END,    31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{"7",   1'b0, 1'b0, TK_PRINT,           31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE},
    '{8'h00, 1'b1, 1'b1, llt_pkg::TK_END,    31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE}
  };

  logic_language_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_int_value    (out_int_value),
    .out_int_overflow (out_int_overflow),
    .out_ident_length (out_ident_length),
    .out_error_kind   (out_error_kind),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || (c >= "a" && c <= "z");
  endfunction

  function automatic lex_tok_t make_tok(input logic [4:0] kind, input logic [30:0] ival,
                                        input logic ovf, input logic [7:0] len,
                                        input logic [1:0] err);
    lex_tok_t t;
    t = '{kind, ival, ovf, len, err, 1'b0};
    return t;
  endfunction

  // Variable, keyword or atom for the identifier held in s
  function automatic logic [4:0] ident_kind(input lex_state_t s);
    logic [4:0] kind;
    logic       same;
    kind = llt_pkg::TK_ATOM;
    if (s.upper) return llt_pkg::TK_VAR;
    for (int k = 0; k < 8; k++) begin
      if (kind == llt_pkg::TK_ATOM && s.cnt == kw_spell[k].len()) begin
        same = 1'b1;
        for (int i = 0; i < kw_spell[k].len(); i++) begin
          if (s.pfx[i] != kw_spell[k][i]) same = 1'b0;
        end
        if (same) kind = 5'(k);
      end
    end
    return kind;
  endfunction

  // One byte through the lexer: updates s, returns up to two tokens in order
  function automatic void lex_step(inout lex_state_t s, input logic [7:0] c,
                                   input logic eoi, output lex_tok_t r0,
                                   output lex_tok_t r1, output int n);
    lex_tok_t    res [2];
    logic        restart;
    logic [34:0] v;
    res[0] = '0;
    res[1] = '0;
    n = 0;
    restart = 1'b0;
    case (s.mode)
      MD_HALT: ;
      MD_COMMENT: begin
        if (eoi || c == 8'h00) restart = 1'b1;
        else if (c == "\n") s.mode = MD_START;
      end
      MD_QMARK, MD_COLON: begin
        if (!eoi && c == "-") begin
          res[n] = make_tok(s.mode == MD_QMARK ? llt_pkg::TK_QUERY : llt_pkg::TK_ASSIGN,
                            31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE);
          n++;
          s.mode = MD_START;
        end else begin
          res[n] = make_tok(llt_pkg::TK_ERR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_DASH);
          n++;
          s.mode = MD_HALT;
        end
      end
      MD_INT: begin
        if (!eoi && is_digit(c)) begin
          v = 35'(s.acc) * 35'd10 + 35'(c - "0");
          if (v > 35'(llt_pkg::INT_MAX31)) begin
            v = 35'(llt_pkg::INT_MAX31);
            s.ovf = 1'b1;
          end
          s.acc = v[30:0];
        end else begin
          res[n] = make_tok(llt_pkg::TK_INT, s.acc, s.ovf, 8'd0, llt_pkg::ERR_NONE);
          n++;
          restart = 1'b1;
        end
      end
      MD_IDENT: begin
        if (!eoi && (is_alpha(c) || is_digit(c))) begin
          if (s.cnt >= llt_pkg::MAX_ID_LEN) begin
            res[n] = make_tok(llt_pkg::TK_ERR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_LONG);
            n++;
            s.mode = MD_HALT;
          end else begin
            if (s.cnt < llt_pkg::PREFIX_LEN) s.pfx[s.cnt[2:0]] = c;
            s.cnt++;
          end
        end else begin
          res[n] = make_tok(ident_kind(s), 31'd0, 1'b0, s.cnt, llt_pkg::ERR_NONE);
          n++;
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    // Byte handled as the first byte of a new token
    if (restart) begin
      s.mode = MD_START;
      if (eoi || c == 8'h00) begin
        res[n] = make_tok(llt_pkg::TK_END, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE);
        n++;
      end else begin
        case (c)
          " ", "\n": ;
          "#": s.mode = MD_COMMENT;
          "?": s.mode = MD_QMARK;
          ":": s.mode = MD_COLON;
          "(": begin
            res[n] = make_tok(llt_pkg::TK_LPAR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          ")": begin
            res[n] = make_tok(llt_pkg::TK_RPAR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          "[": begin
            res[n] = make_tok(llt_pkg::TK_LSPAR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          "]": begin
            res[n] = make_tok(llt_pkg::TK_RSPAR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          ".": begin
            res[n] = make_tok(llt_pkg::TK_PERIOD, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          ",": begin
            res[n] = make_tok(llt_pkg::TK_COMMA, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_NONE); n++;
          end
          default: begin
            if (is_digit(c)) begin
              s.mode = MD_INT;
              s.acc = 31'(c - "0");
              s.ovf = 1'b0;
            end else if (is_alpha(c)) begin
              s.mode = MD_IDENT;
              s.pfx = '0;
              s.pfx[0] = c;
              s.cnt = 8'd1;
              s.upper = is_upper(c);
            end else begin
              res[n] = make_tok(llt_pkg::TK_ERR, 31'd0, 1'b0, 8'd0, llt_pkg::ERR_CHAR);
              n++;
              s.mode = MD_HALT;
            end
          end
        endcase
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    r0 = res[0];
    r1 = res[1];
  endfunction

  // True when this byte would make the lexer emit an error token
  function automatic logic causes_error(input logic [7:0] c, input logic eoi);
    lex_state_t s;
    lex_tok_t   r0, r1;
    int         n;
    s = lex;
    lex_step(s, c, eoi, r0, r1, n);
    return (n == 1 && r0.kind == llt_pkg::TK_ERR) || (n == 2 && r1.kind == llt_pkg::TK_ERR);
  endfunction

  // top 51: letters only, top 61: letters and digits
  function automatic logic [7:0] rand_char(input int top);
    int r;
    r = int'($urandom_range(top));
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return 8'("0" + r - 52);
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // One input transaction; predicted tokens are queued once it is taken
  task automatic send(input logic [7:0] c, input logic eoi, input logic typed,
                      input lex_tok_t want);
    lex_tok_t r0, r1;
    int       n;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    bytes_in++;
    lex_step(lex, c, eoi, r0, r1, n);
    if (typed) begin
      want.last = 1'b1;
      if (n == 2) r1 = want;
      else r0 = want;
    end
    if (n > 0) pending_toks.push_back(r0);
    if (n > 1) pending_toks.push_back(r1);
  endtask

  // Random text must not halt the lexer, so bytes that would are dropped
  task automatic offer(input logic [7:0] c, input logic eoi);
    if (!causes_error(c, eoi)) send(c, eoi, 1'b0, '0);
  endtask

  task automatic offer_text(input string t);
    for (int i = 0; i < t.len(); i++) offer(t[i], 1'b0);
  endtask

  // Source bytes: reset, directed table, random text, one closing error, then bytes while halted
  initial begin
    int         pick;
    int         len;
    logic [7:0] c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'h00;
    in_end_of_input = 1'b0;
    lex = '{MD_START, 31'd0, 1'b0, 8'd0, '0, 1'b0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].typed,
           make_tok(dir_rows[i].kind, dir_rows[i].ival, dir_rows[i].ovf,
                    dir_rows[i].len, dir_rows[i].err));
    end

    while (bytes_in < RANDOM_BYTES) begin
      idle_pct = (bytes_in >= 800 && bytes_in < 1100) ? 0 : IDLE_PCT;
      if (bytes_in >= 300) hold_go = 1'b1;
      pick = int'($urandom_range(99));
      if (pick < 20) begin
        // integers, including the saturation edge
        case ($urandom_range(9))
          0: offer_text("2147483647");
          1: offer_text("2147483648");
          2: repeat ($urandom_range(10, 13)) offer(8'("0" + $urandom_range(9)), 1'b0);
          default: repeat ($urandom_range(1, 5)) offer(8'("0" + $urandom_range(9)), 1'b0);
        endcase
        if ($urandom_range(1)) offer(seps[$urandom_range(seps.len() - 1)], 1'b0);
      end else if (pick < 45) begin
        // keywords, atoms and variables; now and then the longest allowed
        if ($urandom_range(2) == 0) begin
          offer_text(kw_spell[$urandom_range(7)]);
        end else begin
          len = ($urandom_range(49) == 0) ? llt_pkg::MAX_ID_LEN - int'($urandom_range(2))
                                          : int'($urandom_range(1, 8));
          offer(rand_char(51), 1'b0);
          repeat (len - 1) offer(rand_char(61), 1'b0);
        end
        if ($urandom_range(1)) offer(seps[$urandom_range(seps.len() - 1)], 1'b0);
      end else if (pick < 65) begin
        case ($urandom_range(7))
          0: offer_text("?-");
          1: offer_text(":-");
          default: offer(seps[$urandom_range(2, seps.len() - 1)], 1'b0);
        endcase
      end else if (pick < 75) begin
        // comment with arbitrary bytes, closed by newline or end of input
        offer("#", 1'b0);
        repeat ($urandom_range(0, 6)) offer(8'($urandom_range(1, 255)), 1'b0);
        case ($urandom_range(3))
          0: offer(8'($urandom_range(255)), 1'b1);
          1: offer(8'h00, 1'b0);
          default: offer("\n", 1'b0);
        endcase
      end else if (pick < 85) begin
        offer($urandom_range(1) ? " " : "\n", 1'b0);
      end else if (pick < 90) begin
        offer(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        offer(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
      // never leave a lone '?' or ':' waiting for its dash
      if (lex.mode inside {MD_QMARK, MD_COLON}) offer("-", 1'b0);
    end
    idle_pct = IDLE_PCT;

    // One error per run, since only reset leaves the halted state
    offer("\n", 1'b0);
    case ($urandom_range(3))
      0: begin
        send("?", 1'b0, 1'b0, '0);
        do c = 8'($urandom_range(255)); while (c == "-");
        send(c, 1'b0, 1'b0, '0);
      end
      1: begin
        send(":", 1'b0, 1'b0, '0);
        send(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      end
      2: begin
        do c = 8'($urandom_range(1, 255)); while (!causes_error(c, 1'b0));
        send(c, 1'b0, 1'b0, '0);
      end
      default: begin
        send(rand_char(51), 1'b0, 1'b0, '0);
        repeat (llt_pkg::MAX_ID_LEN) send(rand_char(61), 1'b0, 1'b0, '0);
      end
    endcase
    // halted: these are taken and produce nothing
    repeat (12) send(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_toks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Token sink: random back-pressure plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Compare each token transaction with the oldest predicted token
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_toks.size() == 0) begin
        $error("token with nothing pending: kind %0d", out_token_kind);
        fails++;
      end else begin
        head = pending_toks.pop_front();
        check_field("token_kind", 64'(head.kind), 64'(out_token_kind));
        check_field("int_value", 64'(head.ival), 64'(out_int_value));
        check_field("int_overflow", 64'(head.ovf), 64'(out_int_overflow));
        check_field("ident_length", 64'(head.len), 64'(out_ident_length));
        check_field("error_kind", 64'(head.err), 64'(out_error_kind));
        check_field("last", 64'(head.last), 64'(out_last));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
design/llt_pkg.sv
design/llt_front.sv
design/llt_fifo.sv
design/llt_back.sv
design/logic_language_tokenizer.sv
tb/sv/logic_language_tokenizer_test.sv
